>>> sv/sha256_pkg.sv
// Package with the shared types, constants and round functions of the SHA-256 compressor.
`timescale 1ns / 1ps

package sha256_pkg;

    // Block geometry and round count.
    localparam int WORDS_PER_BLOCK = 16;
    localparam int NUM_ROUNDS      = 64;
    localparam int DIGEST_WORDS    = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int WORD_CNT_W = $clog2(WORDS_PER_BLOCK);
    localparam int ROUND_W    = $clog2(NUM_ROUNDS);
    localparam int DIGEST_W   = $clog2(DIGEST_WORDS);

    // Request arriving from the message source.
    typedef struct packed {
        logic [31:0] message_word;
        logic        first_block;
        logic        final_block;
    } msg_req_t;

    // Request handed to the digest consumer.
    typedef struct packed {
        logic [31:0]         digest_word;
        logic [DIGEST_W-1:0] word_index;
        logic                last_word;
    } digest_req_t;

    // Classified word held in the queue between the front and the back.
    typedef struct packed {
        logic [31:0] word;
        logic        load_iv;
        logic        block_end;
        logic        emit;
    } blk_word_t;

    typedef logic [DIGEST_WORDS-1:0][31:0] hash_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // Standard initial hash value.
    function automatic hash_t iv_hash();
        hash_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        return h;
    endfunction

    // Round constants.
    function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

>>> sv/sha256_block_compressor.sv
// Top level of the SHA-256 block compressor: front end, word queue and compression engine.
//
//   Channel   Direction  Handshake                  Payload
//   msg       in         msg_valid / msg_stall      message_word, first_block, final_block
//   digest    out        digest_valid / digest_stall digest_word, word_index, last_word
//
// A block is loaded word by word, runs through the rounds and the chaining add, and, when
// final, emits its eight digest words. The single shared round unit of the compression
// engine pops no new words until a block has finished all of these steps.
// Words keep entering the queue during compression until it fills, and then msg_stall rises.
// A stalled digest word holds in the output register; the engine waits in its output phase.
// Reset is asynchronous and loads the initial hash value; no clearing pass is needed.
`timescale 1ns / 1ps

module sha256_block_compressor #(
    parameter int QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    msg_valid,
    output logic                    msg_stall,
    input  sha256_pkg::msg_req_t    msg,
    output logic                    digest_valid,
    input  logic                    digest_stall,
    output sha256_pkg::digest_req_t digest
);
    import sha256_pkg::*;

    blk_word_t push_data;
    blk_word_t pop_data;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_empty;

    // Word intake and classification.
    sha256_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .msg        (msg),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Decoupling queue.
    sha256_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // Compression and digest output.
    sha256_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .pop_data     (pop_data),
        .queue_empty  (queue_empty),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

endmodule

>>> sv/sha256_queue.sv
// Small register queue that decouples the word front end from the compression engine.
`timescale 1ns / 1ps

module sha256_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sha256_pkg::blk_word_t push_data,
    output logic                  full,
    input  logic                  pop,
    output sha256_pkg::blk_word_t pop_data,
    output logic                  empty
);
    import sha256_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blk_word_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill-count update with explicit wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/sha256_front.sv
// Front end that accepts message words, tracks the block position and classifies each word.
`timescale 1ns / 1ps

module sha256_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  msg_valid,
    output logic                  msg_stall,
    input  sha256_pkg::msg_req_t  msg,
    output logic                  push,
    output sha256_pkg::blk_word_t push_data,
    input  logic                  queue_full
);
    import sha256_pkg::*;

    logic [WORD_CNT_W-1:0] word_count_reg, word_count_next;
    logic                  accept;
    logic                  at_start;
    logic                  at_end;

    assign msg_stall = queue_full;
    assign accept    = msg_valid && !queue_full;
    assign at_start  = (word_count_reg == '0);
    assign at_end    = (word_count_reg == WORD_CNT_W'(WORDS_PER_BLOCK - 1));

    // The first flag counts only on word zero, the final flag only on the last word.
    always_comb
    begin
        push                = accept;
        push_data.word      = msg.message_word;
        push_data.load_iv   = at_start && msg.first_block;
        push_data.block_end = at_end;
        push_data.emit      = at_end && msg.final_block;
    end

    // Position of the next word within the block; wraps after the last word.
    always_comb
    begin
        word_count_next = word_count_reg;
        if (accept)
        begin
            word_count_next = at_end ? '0 : word_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
        end
        else
        begin
            word_count_reg <= word_count_next;
        end
    end

endmodule

>>> sv/sha256_back.sv
// Compression engine: schedule window, one round per cycle, chaining update and digest output.
`timescale 1ns / 1ps

module sha256_back (
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     pop,
    input  sha256_pkg::blk_word_t    pop_data,
    input  logic                     queue_empty,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output sha256_pkg::digest_req_t  digest
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_EMIT  = 4'b1000
    } back_state_t;

    back_state_t                       state_reg, state_next;
    hash_t                             cv_reg, cv_next;
    hash_t                             var_reg, var_next;
    logic [WORDS_PER_BLOCK-1:0][31:0]  win_reg, win_next;
    logic [ROUND_W-1:0]                round_reg, round_next;
    logic [DIGEST_W-1:0]               idx_reg, idx_next;
    logic                              emit_reg, emit_next;
    logic                              out_valid_reg, out_valid_next;
    digest_req_t                       out_reg, out_next;
    logic                              out_load;
    logic [31:0]                       sched_word;
    logic [31:0]                       t1, t2, ch, maj;

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;
    assign pop          = (state_reg == ST_LOAD) && !queue_empty;
    assign out_load     = (state_reg == ST_EMIT) && (!out_valid_reg || !digest_stall);

    // Next schedule word from the sliding sixteen-word window.
    assign sched_word = small_sig1(win_reg[14]) + win_reg[9] + small_sig0(win_reg[1]) + win_reg[0];

    // Round function on the working variables a..h.
    always_comb
    begin
        ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^ (var_reg[1] & var_reg[2]);
        t1  = var_reg[7] + big_sig1(var_reg[4]) + ch + round_k(round_reg) + win_reg[0];
        t2  = big_sig0(var_reg[0]) + maj;
    end

    // Sequencer: load sixteen words, run the rounds, fold into the chaining value, emit.
    always_comb
    begin
        state_next = state_reg;
        cv_next    = cv_reg;
        var_next   = var_reg;
        win_next   = win_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        emit_next  = emit_reg;
        out_next   = out_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (pop)
                begin
                    win_next = {pop_data.word, win_reg[WORDS_PER_BLOCK-1:1]};
                    if (pop_data.load_iv)
                    begin
                        cv_next = iv_hash();
                    end
                    if (pop_data.block_end)
                    begin
                        var_next   = cv_reg;
                        emit_next  = pop_data.emit;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                win_next    = {sched_word, win_reg[WORDS_PER_BLOCK-1:1]};
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                round_next  = round_reg + 1'b1;
                if (round_reg == ROUND_W'(NUM_ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    cv_next[i] = cv_reg[i] + var_reg[i];
                end
                idx_next   = '0;
                state_next = emit_reg ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_next.digest_word = cv_reg[idx_reg];
                    out_next.word_index  = idx_reg;
                    out_next.last_word   = (idx_reg == DIGEST_W'(DIGEST_WORDS - 1));
                    idx_next             = idx_reg + 1'b1;
                    if (idx_reg == DIGEST_W'(DIGEST_WORDS - 1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Output register valid: set on a load, cleared once the consumer takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!digest_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cv_reg        <= iv_hash();
            round_reg     <= '0;
            idx_reg       <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cv_reg        <= cv_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
        win_reg <= win_next;
        out_reg <= out_next;
    end

endmodule
